// ===== rtl/tal_pkg.sv =====
// Shared types and constants for the thrust allocation pipeline.
// No dependencies; imported by every module under rtl.
`timescale 1ns / 1ps

package tal_pkg;

  localparam int CMD_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = CMD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = 32;
  localparam int FRAC_BITS = 12;
  localparam int LIM_W     = 8;
  localparam int QW        = 8;
  localparam int NUM_W     = MAG_W + LIM_W;
  localparam int RES_W     = 9;
  localparam int ROW_W     = 48;
  localparam int ROW_REGS  = 4;
  localparam int IN_AXES   = 3;
  localparam int IDX_W     = 3;
  localparam int DIV_STEPS = QW;

  // pipeline stage positions
  localparam int ST_IN   = 0;
  localparam int ST_PROD = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_MAX  = 3;
  localparam int ST_MUL  = 4;
  localparam int ST_DIV0 = 5;
  localparam int ST_OUT  = ST_DIV0 + DIV_STEPS;
  localparam int NSTG    = ST_OUT + 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT = 3'd4;

  localparam logic [LIM_W-1:0] LIMIT_RST = 8'd255;

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [RES_W-1:0] res_t;
  typedef logic [NSTG-1:0]         stage_en_t;

endpackage

// ===== rtl/tal_lane.sv =====
// One thruster lane: coefficient products, then the row sum and its magnitude.
// Depends on tal_pkg.
`timescale 1ns / 1ps

module tal_lane #(
  parameter int NAX = 3
) (
  input  logic                clk,
  input  tal_pkg::stage_en_t  stg_en,
  input  tal_pkg::cmd_t       cmd [0:NAX-1],
  input  tal_pkg::row_t       row,
  output tal_pkg::mag_t       mag_r,
  output logic                neg_r
);
  import tal_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt [0:NAX-1];
  logic signed [PROD_W-1:0] prod_r   [0:NAX-1];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]         abs_w;
  logic                     neg_nxt;

  always_comb begin
    for (int j = 0; j < NAX; j++) begin
      prod_nxt[j] = $signed(row[COEF_W*j +: COEF_W]) * cmd[j];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_PROD]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NAX; j++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[j]);
    end
    neg_nxt = sum_nxt[SUM_W-1];
    abs_w   = neg_nxt ? -sum_nxt : sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_SUM]) begin
      mag_r <= abs_w[MAG_W-1:0];
      neg_r <= neg_nxt;
    end
  end

endmodule

// ===== rtl/tal_max.sv =====
// Merge stage: largest magnitude over all lanes and the over-limit flag.
// Depends on tal_pkg.
`timescale 1ns / 1ps

module tal_max #(
  parameter int LANES = 4
) (
  input  logic                    clk,
  input  tal_pkg::stage_en_t      stg_en,
  input  tal_pkg::mag_t           mag [0:LANES-1],
  input  logic [tal_pkg::LIM_W-1:0] limit,
  output tal_pkg::mag_t           maxmag_r,
  output logic                    scaled_r
);
  import tal_pkg::*;

  mag_t maxmag_nxt;
  logic scaled_nxt;

  always_comb begin
    maxmag_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      if (mag[i] > maxmag_nxt) begin
        maxmag_nxt = mag[i];
      end
    end
    scaled_nxt = maxmag_nxt > MAG_W'({limit, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_MAX]) begin
      maxmag_r <= maxmag_nxt;
      scaled_r <= scaled_nxt;
    end
  end

endmodule

// ===== rtl/tal_scale.sv =====
// Per-lane scaling: mag * limit, restoring divide by the max one quotient bit
// per stage, unscaled if within limit, then sign restore. Depends on tal_pkg.
`timescale 1ns / 1ps

module tal_scale (
  input  logic                      clk,
  input  tal_pkg::stage_en_t        stg_en,
  input  tal_pkg::mag_t             mag,
  input  logic                      neg,
  input  tal_pkg::mag_t             maxmag,
  input  logic                      scaled,
  input  logic [tal_pkg::LIM_W-1:0] limit,
  output tal_pkg::res_t             res_r,
  output logic                      scaled_out_r
);
  import tal_pkg::*;

  mag_t              mag3_r;
  logic              neg3_r;
  logic [NUM_W-1:0]  rem_r [0:DIV_STEPS];
  logic [QW-1:0]     quo_r [0:DIV_STEPS];
  logic [QW-1:0]     sml_r [0:DIV_STEPS];
  mag_t              div_r [0:DIV_STEPS];
  logic              neg_r [0:DIV_STEPS];
  logic              scl_r [0:DIV_STEPS];
  logic [QW-1:0]     quot_w;
  res_t              res_nxt;

  // align with the merge stage
  always_ff @(posedge clk) begin
    if (stg_en[ST_MAX]) begin
      mag3_r <= mag;
      neg3_r <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_MUL]) begin
      rem_r[0] <= NUM_W'(mag3_r) * NUM_W'(limit);
      quo_r[0] <= '0;
      // unscaled result: mag stays within limit << 12, so 8 bits hold it
      sml_r[0] <= mag3_r[FRAC_BITS +: QW];
      div_r[0] <= maxmag;
      neg_r[0] <= neg3_r;
      scl_r[0] <= scaled;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [NUM_W-1:0] dsh_w;
    logic             ge_w;

    assign dsh_w = NUM_W'(div_r[j]) << (QW - 1 - j);
    assign ge_w  = rem_r[j] >= dsh_w;

    always_ff @(posedge clk) begin
      if (stg_en[ST_DIV0 + j]) begin
        rem_r[j+1] <= ge_w ? rem_r[j] - dsh_w : rem_r[j];
        quo_r[j+1] <= {quo_r[j][QW-2:0], ge_w};
        sml_r[j+1] <= sml_r[j];
        div_r[j+1] <= div_r[j];
        neg_r[j+1] <= neg_r[j];
        scl_r[j+1] <= scl_r[j];
      end
    end
  end

  always_comb begin
    quot_w  = scl_r[DIV_STEPS] ? quo_r[DIV_STEPS] : sml_r[DIV_STEPS];
    res_nxt = neg_r[DIV_STEPS] ? -$signed({1'b0, quot_w}) : $signed({1'b0, quot_w});
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_OUT]) begin
      res_r        <= res_nxt;
      scaled_out_r <= scl_r[DIV_STEPS];
    end
  end

endmodule

// ===== rtl/thrust_allocation_with_scaling.sv =====
// Thrust allocation with saturation scaling, top level.
// One request per cycle while in_stall is low.
// A shared input register feeds a 13-stage pipeline per lane, eight stages of it a restoring
// divider that retires one quotient bit per stage. Stalls hold only full stages, bubbles collapse.
// Reset (rst_n low, synchronous) empties the pipeline, clears coefficients, limit to 255.
// Depends on tal_pkg, tal_lane, tal_max, tal_scale.
`timescale 1ns / 1ps

module thrust_allocation_with_scaling #(
  parameter int THRUSTERS = 4,
  parameter int AXES      = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tal_pkg::CMD_W-1:0]  in_command_x,
  input  logic signed [tal_pkg::CMD_W-1:0]  in_command_y,
  input  logic signed [tal_pkg::CMD_W-1:0]  in_command_yaw,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tal_pkg::RES_W-1:0]  out_thrust_zero,
  output logic signed [tal_pkg::RES_W-1:0]  out_thrust_one,
  output logic signed [tal_pkg::RES_W-1:0]  out_thrust_two,
  output logic signed [tal_pkg::RES_W-1:0]  out_thrust_three,
  output logic                              out_was_scaled,
  input  logic                              cfg_wr_en,
  input  logic [tal_pkg::IDX_W-1:0]         cfg_index,
  input  logic [tal_pkg::ROW_W-1:0]         cfg_wdata
);
  import tal_pkg::*;

  // thrusters past the row registers and axes past the inputs carry zero
  localparam int LANES = (THRUSTERS < ROW_REGS) ? THRUSTERS : ROW_REGS;
  localparam int NAX   = (AXES < IN_AXES) ? AXES : IN_AXES;

  row_t              row_r [0:LANES-1];
  logic [LIM_W-1:0]  limit_r;
  stage_en_t         vld_r;
  stage_en_t         stg_en;
  cmd_t              cmd_r [0:NAX-1];
  cmd_t              cmd_in [0:IN_AXES-1];
  mag_t              mag_w [0:LANES-1];
  logic              neg_w [0:LANES-1];
  res_t              res_w [0:LANES-1];
  logic              scl_w [0:LANES-1];
  res_t              res_all [0:ROW_REGS-1];
  mag_t              maxmag_w;
  logic              scaled_w;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr_en && cfg_index == REG_LIMIT) begin
      limit_r <= cfg_wdata[LIM_W-1:0];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        row_r[i] <= '0;
      end else if (cfg_wr_en && cfg_index == REG_ROW0 + IDX_W'(i)) begin
        row_r[i] <= cfg_wdata;
      end
    end
  end

  // a stage may load when some stage at or after it is empty, or the output drains
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign stg_en[k] = !out_stall || !(&vld_r[NSTG-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[ST_IN]) begin
        vld_r[ST_IN] <= in_valid;
      end
      for (int k = ST_IN + 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !stg_en[ST_IN];
  assign out_valid = vld_r[NSTG-1];

  // input request register
  assign cmd_in[0] = in_command_x;
  assign cmd_in[1] = in_command_y;
  assign cmd_in[2] = in_command_yaw;

  always_ff @(posedge clk) begin
    if (stg_en[ST_IN]) begin
      for (int j = 0; j < NAX; j++) begin
        cmd_r[j] <= cmd_in[j];
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tal_lane #(
      .NAX(NAX)
    ) u_lane (
      .clk    (clk),
      .stg_en (stg_en),
      .cmd    (cmd_r),
      .row    (row_r[i]),
      .mag_r  (mag_w[i]),
      .neg_r  (neg_w[i])
    );

    tal_scale u_scale (
      .clk          (clk),
      .stg_en       (stg_en),
      .mag          (mag_w[i]),
      .neg          (neg_w[i]),
      .maxmag       (maxmag_w),
      .scaled       (scaled_w),
      .limit        (limit_r),
      .res_r        (res_w[i]),
      .scaled_out_r (scl_w[i])
    );
  end

  tal_max #(
    .LANES(LANES)
  ) u_max (
    .clk      (clk),
    .stg_en   (stg_en),
    .mag      (mag_w),
    .limit    (limit_r),
    .maxmag_r (maxmag_w),
    .scaled_r (scaled_w)
  );

  for (genvar k = 0; k < ROW_REGS; k++) begin : g_res
    if (k < LANES) begin : g_on
      assign res_all[k] = res_w[k];
    end else begin : g_off
      assign res_all[k] = '0;
    end
  end

  assign out_thrust_zero  = res_all[0];
  assign out_thrust_one   = res_all[1];
  assign out_thrust_two   = res_all[2];
  assign out_thrust_three = res_all[3];
  assign out_was_scaled   = scl_w[0];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> &vld_r)
    else $error("input stalled while a pipeline stage is empty");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[ST_IN])
    else $error("accepted request not captured");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_thrust_zero != -9'sd256 && out_thrust_one != -9'sd256)
    else $error("thruster command beyond limit range");

endmodule
